// File: hw/rtl/hpq_pkg.sv
package hpq_pkg;

  // operation carried by an input beat
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CHK,
    S_DN_CMP,
    S_FINISH
  } hpq_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_PUSH,
    DP_POP,
    DP_FULL,
    DP_EMPTY,
    DP_UP_CHK,
    DP_UP_CMP,
    DP_DN_LOAD,
    DP_DN_CHK,
    DP_DN_CMP
  } hpq_op_t;

  typedef struct packed {
    hpq_op_t op;
    logic    load_out;
  } hpq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_move;
    logic dn_leaf;
    logic dn_move;
    logic out_busy;
  } hpq_stat_t;

endpackage

// File: hw/rtl/hpq_ifs.sv
interface hpq_in_if #(
  parameter int KEY_BITS = 32
);
  logic                valid;
  logic                ready;
  logic                kind;
  logic [KEY_BITS-1:0] key_in;

  modport source (output valid, output kind, output key_in, input ready);
  modport sink   (input valid, input kind, input key_in, output ready);
endinterface

interface hpq_out_if #(
  parameter int KEY_BITS = 32,
  parameter int CNT_BITS = 7
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key_out;
  logic [1:0]          status;
  logic [CNT_BITS-1:0] entry_count;

  modport source (output valid, output key_out, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input key_out, input status, input entry_count,
                  output ready);
endinterface

// File: hw/rtl/binary_heap_priority_queue_core.sv
// Binary heap priority queue, min or max order.
// in_ch: one beat per operation, kind selects push of key_in or pop of the top.
// out_ch: exactly one beat per operation, carrying the popped key (0 on push or
//   refused op), status (done, pop on empty, push on full) and entry count.
// cfg_we/cfg_wdata: writes order_mode (0 = smallest first, 1 = largest first);
//   write only while the queue is idle.
// One operation is in flight at a time; in_ch.ready is high while idle.
// A push moves its key from the new leaf toward the root and a pop moves the
// last entry down from the root, S swaps in all (at most log2(CAPACITY));
// refused ops go straight to the result register. Each level is a read of
// the heap RAM and a compare-and-write on its single write port. The next
// beat is accepted in the cycle after the result register loads.
// The result sits in an output register, so the next operation is accepted
// while it waits; if it is still not taken when the next result is ready,
// the queue holds that result and stays busy until the receiver takes a beat.
// Reset (rst_n low at a clock edge) empties the queue and sets smallest-first
// order; the heap RAM itself is not cleared.
module binary_heap_priority_queue_core
  import hpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  hpq_in_if.sink      in_ch,
  hpq_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  hpq_cmd_t  cmd;
  hpq_stat_t stat;

  hpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hpq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .AW       (AW),
    .CW       (CW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_key     (in_ch.key_in),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_key    (out_ch.key_out),
    .out_status (out_ch.status),
    .out_count  (out_ch.entry_count)
  );

endmodule

// File: hw/rtl/hpq_ctrl.sv
module hpq_ctrl
  import hpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_ready,
  input  hpq_stat_t stat,
  output hpq_cmd_t  cmd
);

  hpq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_POP) begin
            state_nxt = stat.empty ? S_FINISH : S_DN_LOAD;
          end else begin
            state_nxt = stat.full ? S_FINISH : S_UP_CHK;
          end
        end
      end
      S_UP_CHK:  state_nxt = stat.pos_zero ? S_FINISH : S_UP_CMP;
      S_UP_CMP:  state_nxt = stat.up_move ? S_UP_CHK : S_FINISH;
      S_DN_LOAD: state_nxt = S_DN_CHK;
      S_DN_CHK:  state_nxt = stat.dn_leaf ? S_FINISH : S_DN_CMP;
      S_DN_CMP:  state_nxt = stat.dn_move ? S_DN_CHK : S_FINISH;
      S_FINISH: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = DP_NOP;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_POP) begin
            cmd.op = stat.empty ? DP_EMPTY : DP_POP;
          end else begin
            cmd.op = stat.full ? DP_FULL : DP_PUSH;
          end
        end
      end
      S_UP_CHK:  cmd.op = DP_UP_CHK;
      S_UP_CMP:  cmd.op = DP_UP_CMP;
      S_DN_LOAD: cmd.op = DP_DN_LOAD;
      S_DN_CHK:  cmd.op = DP_DN_CHK;
      S_DN_CMP:  cmd.op = DP_DN_CMP;
      S_FINISH:  cmd.load_out = !stat.out_busy;
      default:   cmd.op = DP_NOP;
    endcase
  end

endmodule

// File: hw/rtl/hpq_dp.sv
module hpq_dp
  import hpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hpq_cmd_t            cmd,
  output hpq_stat_t           stat,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [KEY_BITS-1:0] out_key,
  output logic [1:0]          out_status,
  output logic [CW-1:0]       out_count
);

  localparam int XW = AW + 2;

  // heap RAM: one write port, two registered read ports
  logic [KEY_BITS-1:0] mem [CAPACITY];
  logic [KEY_BITS-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0]       rd_a_addr, rd_b_addr, wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic                wr_en;

  logic                order_mode_r;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [KEY_BITS-1:0] pend_key_r, pend_key_nxt;
  logic [1:0]          pend_st_r, pend_st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic [1:0]          out_st_r, out_st_nxt;
  logic [CW-1:0]       out_cnt_r, out_cnt_nxt;

  logic [CW-1:0]       last_idx;
  logic [AW-1:0]       parent;
  logic [XW-1:0]       left_x, right_x, fill_x;
  logic                right_ok, use_right;
  logic [AW-1:0]       right_addr, pick_idx;
  logic [KEY_BITS-1:0] pick_val;

  function automatic logic better(input logic [KEY_BITS-1:0] a,
                                  input logic [KEY_BITS-1:0] b,
                                  input logic                mode);
    better = mode ? (a > b) : (a < b);
  endfunction

  assign last_idx   = fill_r - CW'(1);
  assign parent     = (pos_r - AW'(1)) >> 1;
  assign left_x     = XW'({pos_r, 1'b1});
  assign right_x    = left_x + XW'(1);
  assign fill_x     = XW'(fill_r);
  assign right_ok   = right_x < fill_x;
  assign right_addr = right_ok ? right_x[AW-1:0] : left_x[AW-1:0];
  // equal children go right
  assign use_right  = right_ok && !better(rd_a_r, rd_b_r, order_mode_r);
  assign pick_val   = use_right ? rd_b_r : rd_a_r;
  assign pick_idx   = use_right ? right_x[AW-1:0] : left_x[AW-1:0];

  assign stat.full     = fill_r == CW'(CAPACITY);
  assign stat.empty    = fill_r == '0;
  assign stat.pos_zero = pos_r == '0;
  assign stat.up_move  = better(key_r, rd_a_r, order_mode_r);
  assign stat.dn_leaf  = left_x >= fill_x;
  assign stat.dn_move  = better(pick_val, key_r, order_mode_r);
  assign stat.out_busy = out_valid_r && !out_ready;

  always_comb begin
    key_nxt      = key_r;
    pos_nxt      = pos_r;
    fill_nxt     = fill_r;
    pend_key_nxt = pend_key_r;
    pend_st_nxt  = pend_st_r;
    wr_en        = 1'b0;
    wr_addr      = pos_r;
    wr_data      = key_r;
    rd_a_addr    = parent;
    rd_b_addr    = right_addr;
    case (cmd.op)
      DP_PUSH: begin
        key_nxt      = in_key;
        pos_nxt      = fill_r[AW-1:0];
        fill_nxt     = fill_r + CW'(1);
        pend_key_nxt = '0;
        pend_st_nxt  = ST_DONE;
      end
      DP_FULL: begin
        pend_key_nxt = '0;
        pend_st_nxt  = ST_FULL;
      end
      DP_EMPTY: begin
        pend_key_nxt = '0;
        pend_st_nxt  = ST_EMPTY;
      end
      DP_POP: begin
        fill_nxt    = last_idx;
        pos_nxt     = '0;
        pend_st_nxt = ST_DONE;
        rd_a_addr   = '0;
        rd_b_addr   = last_idx[AW-1:0];
      end
      DP_DN_LOAD: begin
        pend_key_nxt = rd_a_r;
        key_nxt      = rd_b_r;
      end
      DP_UP_CHK: begin
        // at the root the moving key settles, otherwise fetch the parent
        wr_en = stat.pos_zero;
      end
      DP_UP_CMP: begin
        wr_en = 1'b1;
        if (stat.up_move) begin
          wr_data = rd_a_r;
          pos_nxt = parent;
        end
      end
      DP_DN_CHK: begin
        wr_en     = stat.dn_leaf;
        rd_a_addr = left_x[AW-1:0];
      end
      DP_DN_CMP: begin
        wr_en = 1'b1;
        if (stat.dn_move) begin
          wr_data = pick_val;
          pos_nxt = pick_idx;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_key_nxt   = pend_key_r;
      out_st_nxt    = pend_st_r;
      out_cnt_nxt   = fill_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_mode_r <= 1'b0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_mode_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    pend_key_r <= pend_key_nxt;
    pend_st_r  <= pend_st_nxt;
    out_key_r  <= out_key_nxt;
    out_st_r   <= out_st_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_key    = out_key_r;
  assign out_status = out_st_r;
  assign out_count  = out_cnt_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("heap fill count above capacity");

  a_full_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_FULL |=> $stable(fill_r))
    else $error("refused push changed the fill count");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("result beat raised without a load");

  a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (XW'(wr_addr) < fill_x) || (cmd.op == DP_DN_CHK) || (cmd.op == DP_DN_CMP))
    else $error("sift-up write beyond the heap end");

endmodule
